// ===== design/hsfd_pkg.sv =====
// hsfd_pkg: shared types and constants of the header synced frame decoder
// used by the front, the queue, the back and the top level; no dependencies
`default_nettype none

package hsfd_pkg;

  // the channel fields of the configuration always have sixteen slots
  localparam int NUM_SLOTS = 16;
  // widest frame is eight header bytes plus sixteen four-byte channels
  localparam int LEN_W     = 8;

  localparam logic [31:0] SIGN_BIT8  = 32'h0000_0080;
  localparam logic [31:0] SIGN_BIT16 = 32'h0000_8000;
  localparam logic [31:0] EXT_MASK8  = 32'hFFFF_FF00;
  localparam logic [31:0] EXT_MASK16 = 32'hFFFF_0000;

  typedef enum logic [2:0] {
    REG_HEADER_LENGTH  = 3'd0,
    REG_HEADER_BYTES   = 3'd1,
    REG_CHANNEL_COUNT  = 3'd2,
    REG_CHANNEL_WIDTHS = 3'd3,
    REG_CHANNEL_LE     = 3'd4,
    REG_CHANNEL_SIGNED = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    WCODE_BYTE     = 2'd0,
    WCODE_HALF     = 2'd1,
    WCODE_WORD     = 2'd2,
    WCODE_RESERVED = 2'd3
  } width_code_t;

  typedef struct packed {
    logic [3:0]  header_length;
    logic [63:0] header_bytes;
    logic [4:0]  channel_count;
    logic [31:0] channel_widths;
    logic [15:0] channel_little_endian;
    logic [15:0] channel_signed;
  } cfg_t;

  // one frame data byte on its way from the front to the back
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] ch;
    logic [1:0] bidx;
    logic [1:0] nbm1;
    logic       last_byte;
    logic       last_chan;
  } qent_t;

endpackage

`default_nettype wire

// ===== design/hsfd_byte_if.sv =====
// hsfd_byte_if: valid/ready channel carrying one raw stream byte
// no dependencies
`default_nettype none

interface hsfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== design/hsfd_result_if.sv =====
// hsfd_result_if: valid/ready channel carrying one decoded channel result
// no dependencies
`default_nettype none

interface hsfd_result_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  channel_index;
  logic signed [31:0] channel_value;
  logic               last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output last_channel, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input last_channel, output ready);
endinterface

`default_nettype wire

// ===== design/header_synced_frame_decoder_top.sv =====
// header_synced_frame_decoder_top: configuration registers and the
// front / queue / back chain; depends on hsfd_pkg, both interfaces and all submodules
//
//  port      dir   kind        transfer moves
//  stream    in    valid/ready one raw stream byte (data_byte)
//  result    out   valid/ready one channel result (index, value, last)
//  wr_*      in    write only  one configuration register
//
// a byte is taken in (intake), the register set checked (setup); an invalid set
// ends there, else header bytes are read and compared until one differs; a
// matching frame then reads and pushes each data byte, one window memory read
// port shared by header and data bytes. the back drains results on its own, so
// a stalled result side holds the front only once the four-entry byte queue fills.
// reset is synchronous; a fill count makes unwritten window entries read as zero.
`default_nettype none

module header_synced_frame_decoder_top #(
  parameter int WINDOW_BYTES = 64,
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_HEADER   = 8
) (
  input  wire         clk,
  input  wire         rst,
  hsfd_byte_if.sink   stream,
  hsfd_result_if.source result,
  input  wire         wr_en,
  input  wire  [2:0]  wr_index,
  input  wire  [63:0] wr_data
);
  import hsfd_pkg::*;

  cfg_t  cfg;
  logic  q_push, q_pop, q_full, q_empty;
  qent_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_length         <= 4'd1;
      cfg.header_bytes          <= 64'd0;
      cfg.channel_count         <= 5'd1;
      cfg.channel_widths        <= 32'd0;
      cfg.channel_little_endian <= 16'hFFFF;
      cfg.channel_signed        <= 16'd0;
    end else if (wr_en) begin
      case (wr_index)
        REG_HEADER_LENGTH:  cfg.header_length         <= wr_data[3:0];
        REG_HEADER_BYTES:   cfg.header_bytes          <= wr_data;
        REG_CHANNEL_COUNT:  cfg.channel_count         <= wr_data[4:0];
        REG_CHANNEL_WIDTHS: cfg.channel_widths        <= wr_data[31:0];
        REG_CHANNEL_LE:     cfg.channel_little_endian <= wr_data[15:0];
        REG_CHANNEL_SIGNED: cfg.channel_signed        <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  hsfd_front #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_HEADER   (MAX_HEADER)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .cfg    (cfg),
    .q_push (q_push),
    .q_data (q_in),
    .q_full (q_full)
  );

  hsfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  hsfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

`default_nettype wire

// ===== design/hsfd_front.sv =====
// hsfd_front: byte intake, window memory, header match and data byte readout
// depends on hsfd_pkg and hsfd_byte_if; feeds hsfd_queue
`default_nettype none

module hsfd_front #(
  parameter int WINDOW_BYTES = 64,
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_HEADER   = 8
) (
  input  wire              clk,
  input  wire              rst,
  hsfd_byte_if.sink        stream,
  input  hsfd_pkg::cfg_t   cfg,
  output logic             q_push,
  output hsfd_pkg::qent_t  q_data,
  input  wire              q_full
);
  import hsfd_pkg::*;

  localparam int AW = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
  localparam int FW = $clog2(WINDOW_BYTES + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_BYTES - 1);
  localparam logic [AW:0]   WIN_X     = (AW+1)'(WINDOW_BYTES);
  localparam logic [FW-1:0] FILL_MAX  = FW'(WINDOW_BYTES);
  localparam logic [LEN_W:0] LEN_MAX  = (LEN_W+1)'(WINDOW_BYTES);
  localparam logic [3:0]    HL_MAX    = 4'(MAX_HEADER);
  localparam logic [4:0]    CC_MAX    = 5'(MAX_CHANNELS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_HREAD = 6'b000100,
    S_HCHK  = 6'b001000,
    S_DREAD = 6'b010000,
    S_DPUSH = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [7:0]    mem [WINDOW_BYTES];
  logic [7:0]    rd_data;
  logic [AW-1:0] wptr;
  logic [FW-1:0] fill;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] age;
  logic          live;
  logic [2:0]    hidx;
  logic [3:0]    ch;
  logic [1:0]    bidx;

  logic [NUM_SLOTS-1:0] used_slot, m1, m2, m4, mres;
  logic [LEN_W-1:0] len_comb, len_q;
  logic             ok_comb, ok_q;

  logic          accept;
  logic [AW:0]   gap, start_sum;
  logic [AW-1:0] start_addr;
  logic [AW-1:0] rd_addr_inc;
  logic [7:0]    rbyte;
  logic [7:0]    hdr_byte;
  logic          hdr_match;
  logic          last_hdr;
  logic [1:0]    wcode;
  logic [1:0]    nbm1;
  logic          last_byte;
  logic          last_chan;

  // frame length from header length and per-width channel counts
  always_comb begin
    for (int c = 0; c < NUM_SLOTS; c++) begin
      used_slot[c] = 5'(c) < cfg.channel_count;
      m1[c]   = used_slot[c] && (cfg.channel_widths[2*c +: 2] == WCODE_BYTE);
      m2[c]   = used_slot[c] && (cfg.channel_widths[2*c +: 2] == WCODE_HALF);
      m4[c]   = used_slot[c] && (cfg.channel_widths[2*c +: 2] == WCODE_WORD);
      mres[c] = used_slot[c] && (cfg.channel_widths[2*c +: 2] == WCODE_RESERVED);
    end
    len_comb = 8'(cfg.header_length) + 8'($countones(m1))
             + (8'($countones(m2)) << 1) + (8'($countones(m4)) << 2);
    ok_comb = (cfg.header_length != 4'd0) && (cfg.header_length <= HL_MAX)
           && (cfg.channel_count != 5'd0) && (cfg.channel_count <= CC_MAX)
           && (mres == '0) && ({1'b0, len_comb} <= LEN_MAX);
  end

  always_ff @(posedge clk) begin
    len_q <= len_comb;
    ok_q  <= ok_comb;
  end

  assign stream.ready = (state == S_IDLE) && !rst;
  assign accept       = stream.valid && stream.ready;

  // oldest frame byte sits (WINDOW_BYTES - len) places after the oldest entry
  assign gap        = (AW+1)'((LEN_W+1)'(WINDOW_BYTES) - {1'b0, len_q});
  assign start_sum  = {1'b0, wptr} + gap;
  assign start_addr = (start_sum >= WIN_X) ? AW'(start_sum - WIN_X) : AW'(start_sum);

  assign rd_addr_inc = (rd_addr == LAST_ADDR) ? '0 : rd_addr + 1'b1;

  // entries never written read as zero
  assign rbyte     = live ? rd_data : 8'd0;
  assign hdr_byte  = cfg.header_bytes[{hidx, 3'b000} +: 8];
  assign hdr_match = (rbyte == hdr_byte);
  assign last_hdr  = (hidx == 3'(cfg.header_length - 4'd1));

  assign wcode     = cfg.channel_widths[{ch, 1'b0} +: 2];
  assign nbm1      = (wcode == WCODE_WORD) ? 2'd3 : ((wcode == WCODE_HALF) ? 2'd1 : 2'd0);
  assign last_byte = (bidx == nbm1);
  assign last_chan = (ch == 4'(cfg.channel_count - 5'd1));

  assign q_push = (state == S_DPUSH) && !q_full;
  // fields in struct order: data, ch, bidx, nbm1, last_byte, last_chan
  assign q_data = {rbyte, ch, bidx, nbm1, last_byte, last_chan};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_SETUP;
      S_SETUP: state_next = ok_q ? S_HREAD : S_IDLE;
      S_HREAD: state_next = S_HCHK;
      S_HCHK: begin
        if (!hdr_match)    state_next = S_IDLE;
        else if (last_hdr) state_next = S_DREAD;
        else               state_next = S_HREAD;
      end
      S_DREAD: state_next = S_DPUSH;
      S_DPUSH: begin
        if (q_push) state_next = (last_byte && last_chan) ? S_IDLE : S_DREAD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wptr  <= '0;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        wptr <= (wptr == LAST_ADDR) ? '0 : wptr + 1'b1;
        if (fill != FILL_MAX) fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) mem[wptr] <= stream.data_byte;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    case (state)
      S_SETUP: begin
        rd_addr <= start_addr;
        age     <= AW'(len_q - 8'd1);
        hidx    <= '0;
      end
      S_HREAD, S_DREAD: live <= FW'(age) < fill;
      S_HCHK: begin
        rd_addr <= rd_addr_inc;
        age     <= age - 1'b1;
        hidx    <= hidx + 1'b1;
        ch      <= '0;
        bidx    <= '0;
      end
      S_DPUSH: begin
        if (q_push) begin
          rd_addr <= rd_addr_inc;
          age     <= age - 1'b1;
          if (last_byte) begin
            bidx <= '0;
            ch   <= ch + 1'b1;
          end else begin
            bidx <= bidx + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/hsfd_queue.sv =====
// hsfd_queue: four-entry fifo of frame data bytes between front and back
// depends on hsfd_pkg
`default_nettype none

module hsfd_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  hsfd_pkg::qent_t  push_data,
  output logic             full,
  input  wire              pop,
  output hsfd_pkg::qent_t  pop_data,
  output logic             empty
);
  import hsfd_pkg::*;

  qent_t      slots [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  assign full     = (count == 3'd4);
  assign empty    = (count == 3'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ===== design/hsfd_back.sv =====
// hsfd_back: assembles channel values from queued bytes, sign-extends them
// and holds each result in an output register; depends on hsfd_pkg, hsfd_result_if
`default_nettype none

module hsfd_back (
  input  wire              clk,
  input  wire              rst,
  input  hsfd_pkg::cfg_t   cfg,
  input  wire              q_empty,
  input  hsfd_pkg::qent_t  q_data,
  output logic             q_pop,
  hsfd_result_if.source    result
);
  import hsfd_pkg::*;

  logic        res_valid;
  logic [3:0]  res_index;
  logic [31:0] res_value;
  logic        res_last;
  logic [31:0] acc;
  logic [1:0]  pos;
  logic [31:0] assembled;
  logic        sgn;
  logic [31:0] extended;

  assign q_pop = !q_empty && (!res_valid || result.ready);

  // byte place inside the value depends on the channel's byte order
  assign pos = cfg.channel_little_endian[q_data.ch] ? q_data.bidx : q_data.nbm1 - q_data.bidx;
  assign assembled = ((q_data.bidx == 2'd0) ? 32'd0 : acc)
                   | (32'(q_data.data) << {pos, 3'b000});

  assign sgn = cfg.channel_signed[q_data.ch];
  always_comb begin
    extended = assembled;
    if (sgn && (q_data.nbm1 == 2'd0) && ((assembled & SIGN_BIT8) != 32'd0))
      extended = assembled | EXT_MASK8;
    if (sgn && (q_data.nbm1 == 2'd1) && ((assembled & SIGN_BIT16) != 32'd0))
      extended = assembled | EXT_MASK16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (result.ready) res_valid <= 1'b0;
      if (q_pop && q_data.last_byte) res_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      acc <= assembled;
      if (q_data.last_byte) begin
        res_index <= q_data.ch;
        res_value <= extended;
        res_last  <= q_data.last_chan;
      end
    end
  end

  assign result.valid         = res_valid;
  assign result.channel_index = res_index;
  assign result.channel_value = $signed(res_value);
  assign result.last_channel  = res_last;

endmodule

`default_nettype wire
